// ===== rtl/hpt_pkg.sv =====
// Shared types, constants and helper functions of the homogeneous point transform.
// Used by every module of the block; depends on nothing.
package hpt_pkg;

  localparam int COEFF_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int CW_EFF      = (COEFF_WIDTH > 32) ? 32 : COEFF_WIDTH;
  localparam int DW          = 32;            // coordinate and coefficient width
  localparam int PW          = 2 * DW;        // product width
  localparam int AW          = PW + 2;        // accumulator of four products
  localparam int MW          = 64;            // magnitude of a dot product
  localparam int QW          = 33;            // quotient bits kept below saturation
  localparam int SH          = QW - FRAC_BITS;
  localparam int FIFO_DEPTH  = 2;

  localparam logic       OP_WRITE  = 1'b0;
  localparam logic       OP_XFORM  = 1'b1;
  localparam logic [1:0] MODE_ROW  = 2'd0;
  localparam logic [1:0] MODE_COL  = 2'd1;
  localparam logic [1:0] MODE_DIR  = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic              op;
    logic [1:0]        row;
    logic [1:0]        col_index;
    logic signed [31:0] element_value;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic [1:0]        mode;
  } hpt_in_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic              w_zero;
    logic              overflow;
  } hpt_out_t;

  typedef enum logic {CMD_WRITE, CMD_XFORM} cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [3:0]         addr;
    logic signed [31:0] coef;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         mode;
  } hpt_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_ACC, BK_DIVSET, BK_DIV, BK_DONE
  } back_state_e;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // Keep the low CW_EFF bits of a written element, sign-extended.
  function automatic logic signed [31:0] fit_coeff(input logic [31:0] raw);
    logic signed [31:0] t;
    t = $signed(raw << (32 - CW_EFF));
    return t >>> (32 - CW_EFF);
  endfunction

  // Signed saturation of a sign and magnitude to 32 bits.
  function automatic sat_t sat32(input logic neg, input logic big, input logic [MW-1:0] mag);
    sat_t r;
    if (!neg) begin
      if (big || mag > MW'(32'h7FFF_FFFF)) begin
        r.val = 32'h7FFF_FFFF;
        r.ovf = 1'b1;
      end else begin
        r.val = mag[31:0];
        r.ovf = 1'b0;
      end
    end else begin
      if (big || mag > MW'(32'h8000_0000)) begin
        r.val = 32'h8000_0000;
        r.ovf = 1'b1;
      end else begin
        r.val = 32'd0 - mag[31:0];
        r.ovf = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/homogeneous_point_transform_top.sv =====
// Homogeneous 4x4 point transform, top level. Depends on hpt_pkg, hpt_front,
// hpt_fifo and hpt_back.
// A transform runs a multiply-accumulate over 16 products on one 32x32
// multiplier, then divides each coordinate by W in the 1-bit-per-cycle divider;
// direction mode and coordinates that saturate early skip the divider, and a
// zero W sets all three results to zero. The back end pops no new command
// until a transform's result is in the output register; a matrix write is
// queued and lands when the idle back end pops it. Reset clears the queue and the
// output valid and loads the identity matrix.
module homogeneous_point_transform_top import hpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  hpt_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hpt_out_t out_item_o
);

  // The front end classifies each request and drops transforms in the unused
  // mode; the queue lets it keep taking requests while the back end works.
  fifo_stat_t stat;
  logic       push, pop;
  hpt_cmd_t   cmd_in, cmd_out;

  hpt_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .stat_i     (stat),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  hpt_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd_in),
    .pop_i  (pop),
    .cmd_o  (cmd_out),
    .stat_o (stat)
  );

  // The back end executes matrix writes and transforms strictly in order, so
  // a write never changes the matrix under a transform in flight.
  hpt_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!stat.empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // A zero divisor gives zero coordinates and never reports overflow.
  a_wzero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.w_zero |->
      !out_item_o.overflow && out_item_o.x_out == 0 &&
      out_item_o.y_out == 0 && out_item_o.z_out == 0)
    else $error("w_zero result with nonzero payload");

  // The back end only pops a queue that holds a request.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  // A push into a full queue would lose a request.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("push into full queue");

endmodule

// ===== rtl/hpt_front.sv =====
// Front end: takes requests, classifies them and pushes commands into the queue.
// Depends on hpt_pkg.
module hpt_front import hpt_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  hpt_in_t    in_item_i,
  input  fifo_stat_t stat_i,
  output logic       push_o,
  output hpt_cmd_t   cmd_o
);

  logic drop;

  // A transform with the unused mode is taken and discarded.
  assign drop       = (in_item_i.op == OP_XFORM) && (in_item_i.mode == MODE_NONE);
  assign in_stall_o = stat_i.full;
  assign push_o     = in_valid_i && !stat_i.full && !drop;

  always_comb begin
    cmd_o.kind = (in_item_i.op == OP_WRITE) ? CMD_WRITE : CMD_XFORM;
    cmd_o.addr = {in_item_i.row, in_item_i.col_index};
    cmd_o.coef = fit_coeff(in_item_i.element_value);
    cmd_o.x    = in_item_i.x_in;
    cmd_o.y    = in_item_i.y_in;
    cmd_o.z    = in_item_i.z_in;
    cmd_o.mode = in_item_i.mode;
  end

endmodule

// ===== rtl/hpt_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on hpt_pkg.
module hpt_fifo import hpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  hpt_cmd_t   cmd_i,
  input  logic       pop_i,
  output hpt_cmd_t   cmd_o,
  output fifo_stat_t stat_o
);

  localparam int PTRW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNTW = $clog2(FIFO_DEPTH + 1);

  hpt_cmd_t          mem_q [FIFO_DEPTH];
  logic [PTRW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == CNTW'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTRW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTRW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/hpt_back.sv =====
// Back end: matrix store, shared multiply-accumulate, bit-serial divider and
// output register. Depends on hpt_pkg.
module hpt_back import hpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  hpt_cmd_t cmd_i,
  output logic     cmd_pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output hpt_out_t out_item_o
);

  back_state_e         state_q, state_d;
  logic signed [31:0]  coef_q [16];
  logic signed [31:0]  x_q, y_q, z_q;
  logic [1:0]          mode_q;
  logic [1:0]          dot_q, term_q, crd_q;
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [MW-1:0]       mag_q [4];
  logic                neg_q [4];
  logic [MW:0]         rem_q;
  logic [QW-1:0]       dvd_q, quo_q;
  logic [5:0]          cnt_q;
  logic [31:0]         res_q [3];
  logic                ovf_q, wz_q;
  logic                out_valid_q;
  hpt_out_t            out_q;

  logic                start, load_out;
  logic [3:0]          caddr;
  logic signed [31:0]  opnd;
  logic signed [AW-1:0] acc_sum;
  logic [MW-1:0]       acc_mag;
  logic [MW-1:0]       n_cur, wmag;
  logic                big, wzero, dir, rneg, ge;
  logic [MW:0]         rem2;
  sat_t                sat_dir, sat_big, sat_div;

  assign dir   = (mode_q == MODE_DIR);
  assign caddr = (mode_q == MODE_COL) ? {dot_q, term_q} : {term_q, dot_q};

  always_comb begin
    unique case (term_q)
      2'd0:    opnd = x_q;
      2'd1:    opnd = y_q;
      2'd2:    opnd = z_q;
      default: opnd = dir ? 32'sd0 : 32'sd1 <<< FRAC_BITS;
    endcase
  end

  assign acc_sum = acc_q + AW'(prod_q);
  assign acc_mag = acc_sum[AW-1] ? MW'(-acc_sum) : MW'(acc_sum);

  assign n_cur   = mag_q[crd_q];
  assign wmag    = mag_q[3];
  assign wzero   = !dir && (wmag == '0);
  assign big     = (n_cur >> SH) >= wmag;
  assign rneg    = neg_q[crd_q] ^ neg_q[3];
  assign rem2    = {rem_q[MW-1:0], dvd_q[QW-1]};
  assign ge      = rem2 >= {1'b0, wmag};
  assign sat_dir = sat32(neg_q[crd_q], 1'b0, n_cur >> FRAC_BITS);
  assign sat_big = sat32(rneg, 1'b1, '0);
  assign sat_div = sat32(rneg, 1'b0, MW'({quo_q[QW-2:0], ge}));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && cmd_i.kind == CMD_XFORM) state_d = BK_MUL;
      end
      BK_MUL: state_d = BK_ACC;
      BK_ACC: begin
        if (term_q == 2'd3 && dot_q == 2'd3) state_d = BK_DIVSET;
        else state_d = BK_MUL;
      end
      BK_DIVSET: begin
        if (wzero) state_d = BK_DONE;
        else if (dir || big) state_d = (crd_q == 2'd2) ? BK_DONE : BK_DIVSET;
        else state_d = BK_DIV;
      end
      BK_DIV: begin
        if (cnt_q == 6'd1) state_d = (crd_q == 2'd2) ? BK_DONE : BK_DIVSET;
      end
      BK_DONE: begin
        if (load_out) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    cmd_pop_o = (state_q == BK_IDLE) && cmd_valid_i;
    start     = cmd_pop_o && (cmd_i.kind == CMD_XFORM);
    load_out  = (state_q == BK_DONE) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        coef_q[i] <= (i % 5 == 0) ? fit_coeff(32'd1 << FRAC_BITS) : 32'sd0;
      end
    end else begin
      state_q <= state_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cmd_pop_o && cmd_i.kind == CMD_WRITE) coef_q[cmd_i.addr] <= cmd_i.coef;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      x_q    <= cmd_i.x;
      y_q    <= cmd_i.y;
      z_q    <= cmd_i.z;
      mode_q <= cmd_i.mode;
      dot_q  <= '0;
      term_q <= '0;
      crd_q  <= '0;
      acc_q  <= '0;
      ovf_q  <= 1'b0;
      wz_q   <= 1'b0;
    end
    unique case (state_q)
      BK_MUL: prod_q <= PW'(opnd) * PW'(coef_q[caddr]);
      BK_ACC: begin
        term_q <= term_q + 1'b1;
        if (term_q == 2'd3) begin
          mag_q[dot_q] <= acc_mag;
          neg_q[dot_q] <= acc_sum[AW-1];
          acc_q        <= '0;
          dot_q        <= dot_q + 1'b1;
        end else begin
          acc_q <= acc_sum;
        end
      end
      BK_DIVSET: begin
        if (wzero) begin
          res_q[0] <= '0;
          res_q[1] <= '0;
          res_q[2] <= '0;
          wz_q     <= 1'b1;
        end else if (dir) begin
          res_q[crd_q] <= sat_dir.val;
          ovf_q        <= ovf_q | sat_dir.ovf;
          crd_q        <= crd_q + 1'b1;
        end else if (big) begin
          res_q[crd_q] <= sat_big.val;
          ovf_q        <= 1'b1;
          crd_q        <= crd_q + 1'b1;
        end else begin
          rem_q <= (MW + 1)'(n_cur >> SH);
          dvd_q <= QW'({n_cur[SH-1:0], {FRAC_BITS{1'b0}}});
          quo_q <= '0;
          cnt_q <= 6'(QW);
        end
      end
      BK_DIV: begin
        rem_q <= ge ? rem2 - {1'b0, wmag} : rem2;
        dvd_q <= dvd_q << 1;
        quo_q <= {quo_q[QW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          res_q[crd_q] <= sat_div.val;
          ovf_q        <= ovf_q | sat_div.ovf;
          crd_q        <= crd_q + 1'b1;
        end
      end
      default: ;
    endcase
    if (load_out) begin
      out_q.x_out    <= res_q[0];
      out_q.y_out    <= res_q[1];
      out_q.z_out    <= res_q[2];
      out_q.w_zero   <= wz_q;
      out_q.overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
